@@ design/multi_alarm_timer_table_top_assert.svh @@
// Assertion macros shared by the multi-alarm timer table RTL.
`ifndef MULTI_ALARM_TIMER_TABLE_TOP_ASSERT_SVH
`define MULTI_ALARM_TIMER_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MATT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("multi_alarm_timer_table: assertion failed");
`define MATT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("multi_alarm_timer_table: assertion failed");
`else
`define MATT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MATT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/matt_pkg.sv @@
// Shared constants and types of the multi-alarm timer table.
package matt_pkg;

	localparam int DEFAULT_ALARM_SLOTS = 16;

	localparam int ACTION_W = 2;
	localparam int ID_W     = 4;
	localparam int DELAY_W  = 31;
	localparam int TIME_W   = 32;

	localparam logic [ACTION_W-1:0] ACT_SET    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

	// One slot record as it sits in the slot memory.
	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [TIME_W-1:0] stamp;
	} slot_entry_t;

endpackage

@@ design/matt_if.sv @@
// Channel interfaces of the multi-alarm timer table: command in, fired alarm out.
interface matt_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [matt_pkg::ACTION_W-1:0] action;
	logic [matt_pkg::ID_W-1:0]     alarm_id;
	logic [matt_pkg::DELAY_W-1:0]  delay_ms;

	modport source (output valid, output action, output alarm_id, output delay_ms, input ready);
	modport sink (input valid, input action, input alarm_id, input delay_ms, output ready);
endinterface

interface matt_fire_if;
	logic                      valid;
	logic                      ready;
	logic [matt_pkg::ID_W-1:0] fired_alarm;
	logic                      last_of_run;

	modport source (output valid, output fired_alarm, output last_of_run, input ready);
	modport sink (input valid, input fired_alarm, input last_of_run, output ready);
endinterface

@@ design/matt_slot_ram.sv @@
// Slot memory: one write port, one read port with registered read data.
module matt_slot_ram #(
	parameter int DEPTH  = matt_pkg::DEFAULT_ALARM_SLOTS,
	parameter int ADDR_W = 4
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  matt_pkg::slot_entry_t wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output matt_pkg::slot_entry_t rd_data
);

	matt_pkg::slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/multi_alarm_timer_table_top.sv @@
// Multi-alarm timer table: slot memory, millisecond clock and the expiry scan.
//
//   channel  dir  payload                       results per transaction
//   cmd      in   action, alarm_id, delay_ms    none for set and cancel
//   fire     out  fired_alarm, last_of_run      0 .. ALARM_SLOTS per tick
//
// Set and cancel act as the command is taken. A tick runs one pass per fired alarm
// and a last pass that finds none: each pass reads every slot from the memory, one per cycle,
// through a two-stage compare and picks the earliest due armed slot.
// A stalled fire channel holds the scan between passes.
// After reset the clock and stamp counter are zero and all slots are disarmed;
// there is no clearing pass, since a slot entry counts only while it is armed.
`include "multi_alarm_timer_table_top_assert.svh"

module multi_alarm_timer_table_top #(
	parameter int ALARM_SLOTS = matt_pkg::DEFAULT_ALARM_SLOTS
) (
	input logic        clk,
	input logic        arst_n,
	matt_cmd_if.sink   cmd,
	matt_fire_if.source fire
);

	localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);
	localparam logic [7:0] SLOTS_B = 8'(ALARM_SLOTS);
	localparam int TW = matt_pkg::TIME_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [TW-1:0]          now_q;
	logic [TW-1:0]          stamp_q;
	logic [ALARM_SLOTS-1:0] armed_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             scan_issue_q;

	logic             v_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	matt_pkg::slot_entry_t entry_s1;

	logic             v_s2;
	logic             last_s2;
	logic             cand_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [TW-1:0]    diff_s2;
	logic [TW-1:0]    age_s2;

	logic             best_v_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [TW-1:0]    best_diff_q;
	logic [TW-1:0]    best_age_q;

	logic             pend_v_q;
	logic [IDX_W-1:0] pend_idx_q;

	logic                      out_v_q;
	logic [matt_pkg::ID_W-1:0] out_id_q;
	logic                      out_last_q;

	logic                  cmd_acc;
	logic                  id_ok;
	logic [IDX_W-1:0]      cmd_idx;
	logic                  set_wr;
	matt_pkg::slot_entry_t wr_entry;
	logic [TW-1:0]         diff_c;
	logic                  due_c;
	logic                  better;
	logic                  out_free;
	logic                  advance;
	logic                  decide_go;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign id_ok     = 8'(cmd.alarm_id) < SLOTS_B;
	assign cmd_idx   = IDX_W'(cmd.alarm_id);
	assign set_wr    = cmd_acc && (cmd.action == matt_pkg::ACT_SET) && id_ok;

	assign wr_entry.expiry = now_q + TW'(cmd.delay_ms);
	assign wr_entry.stamp  = stamp_q + TW'(1);

	// The scan only runs outside the idle state, so a set never writes the entry
	// that is being read in the same cycle.
	matt_slot_ram #(
		.DEPTH  (ALARM_SLOTS),
		.ADDR_W (IDX_W)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (set_wr),
		.wr_addr (cmd_idx),
		.wr_data (wr_entry),
		.rd_en   (scan_issue_q),
		.rd_addr (scan_idx_q),
		.rd_data (entry_s1)
	);

	// A slot is due when its expiry minus the clock is zero or negative.
	assign diff_c = entry_s1.expiry - now_q;
	assign due_c  = (diff_c == '0) || diff_c[TW-1];

	// Earlier expiry wins; on equal expiry the older stamp wins; remaining ties
	// keep the lower slot, which the ascending scan already holds.
	assign better = cand_s2 && (!best_v_q
		|| ($signed(diff_s2) < $signed(best_diff_q))
		|| ((diff_s2 == best_diff_q) && (age_s2 > best_age_q)));

	assign out_free  = !out_v_q || fire.ready;
	assign advance   = !pend_v_q || out_free;
	assign decide_go = (state_q == ST_DECIDE) && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			stamp_q      <= '0;
			armed_q      <= '0;
			scan_idx_q   <= '0;
			scan_issue_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			cand_s2      <= 1'b0;
			best_v_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			v_s1    <= scan_issue_q;
			v_s2    <= v_s1;
			cand_s2 <= v_s1 && armed_q[idx_s1] && due_c;

			// The previous pick goes out once the next pass tells whether it was the last.
			out_v_q <= (decide_go && pend_v_q) || (out_v_q && !fire.ready);

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						case (cmd.action)
							matt_pkg::ACT_SET: begin
								if (id_ok) begin
									stamp_q          <= stamp_q + TW'(1);
									armed_q[cmd_idx] <= 1'b1;
								end
							end
							matt_pkg::ACT_CANCEL: begin
								if (id_ok) begin
									armed_q[cmd_idx] <= 1'b0;
								end
							end
							matt_pkg::ACT_TICK: begin
								now_q        <= now_q + TW'(1);
								scan_idx_q   <= '0;
								scan_issue_q <= 1'b1;
								best_v_q     <= 1'b0;
								state_q      <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_issue_q) begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
						if (scan_idx_q == LAST_IDX) begin
							scan_issue_q <= 1'b0;
						end
					end
					if (better) begin
						best_v_q <= 1'b1;
					end
					if (v_s2 && last_s2) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (advance) begin
						if (best_v_q) begin
							armed_q[best_idx_q] <= 1'b0;
							pend_v_q            <= 1'b1;
							scan_idx_q          <= '0;
							scan_issue_q        <= 1'b1;
							best_v_q            <= 1'b0;
							state_q             <= ST_SCAN;
						end else begin
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_idx_q;
		last_s1 <= scan_issue_q && (scan_idx_q == LAST_IDX);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		diff_s2 <= diff_c;
		age_s2  <= stamp_q - entry_s1.stamp;

		if ((state_q == ST_SCAN) && better) begin
			best_idx_q  <= idx_s2;
			best_diff_q <= diff_s2;
			best_age_q  <= age_s2;
		end

		if (decide_go) begin
			if (pend_v_q) begin
				out_id_q   <= matt_pkg::ID_W'(pend_idx_q);
				out_last_q <= !best_v_q;
			end
			if (best_v_q) begin
				pend_idx_q <= best_idx_q;
			end
		end
	end

	assign fire.valid       = out_v_q;
	assign fire.fired_alarm = out_id_q;
	assign fire.last_of_run = out_last_q;

	`MATT_ASSERT_NEXT(a_set_arms_slot, clk, arst_n, set_wr, armed_q[$past(cmd_idx)])
	`MATT_ASSERT_NEXT(a_pick_disarms, clk, arst_n, decide_go && best_v_q, !armed_q[$past(best_idx_q)])
	`MATT_ASSERT_NOW(a_pending_disarmed, clk, arst_n, pend_v_q, !armed_q[pend_idx_q])

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the multi-alarm timer table: directed table, then random commands.
module testbench;

	localparam int SLOTS = 16;
	localparam int MAX_FIRES = 16;
	localparam int NUM_STEPS = 20;
	localparam int RANDOM_PER_PHASE = 46;
	localparam int DRAIN_CYCLES = 400;
	localparam int LIMIT = 1000000;
	localparam logic [matt_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [matt_pkg::DELAY_W-1:0] DELAY_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [matt_pkg::ID_W-1:0] alarm;
		logic                      last;
	} fire_rec_t;

	// One directed command; typed rows carry up to two expected fired alarms.
	typedef struct packed {
		logic [matt_pkg::ACTION_W-1:0] act;
		logic [matt_pkg::ID_W-1:0]     id;
		logic [matt_pkg::DELAY_W-1:0]  dly;
		logic                          typed;
		logic [1:0]                    n;
		logic [matt_pkg::ID_W-1:0]     first;
		logic [matt_pkg::ID_W-1:0]     second;
	} step_t;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   mismatches;
	int   idle_pct;
	int   stall_pct;

	// Predicted table state.
	logic [matt_pkg::TIME_W-1:0] ms_clock;
	logic [matt_pkg::TIME_W-1:0] set_count;
	logic                        slot_live [SLOTS];
	logic [matt_pkg::TIME_W-1:0] slot_due_at [SLOTS];
	logic [matt_pkg::TIME_W-1:0] slot_set_seq [SLOTS];
	fire_rec_t                   fired_now [MAX_FIRES];
	fire_rec_t                   awaited_fires [$];

	step_t steps [NUM_STEPS] = '{
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b1, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd0,  31'd0,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b1, 2'd1, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd15, 31'd1,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd3,  31'd1,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd7,  31'd2,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b1, 2'd1, 4'd7,  4'd0},
		'{matt_pkg::ACT_SET,    4'd5,  DELAY_MAX, 1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_CANCEL, 4'd5,  31'd0,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_CANCEL, 4'd9,  31'd0,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b1, 2'd0, 4'd0,  4'd0},
		'{ACT_UNUSED,           4'd2,  DELAY_MAX, 1'b1, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd4,  31'd5,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd4,  31'd1,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b1, 2'd1, 4'd4,  4'd0},
		'{matt_pkg::ACT_SET,    4'd10, DELAY_MAX, 1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd6,  31'd1,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_SET,    4'd2,  31'd0,     1'b0, 2'd0, 4'd0,  4'd0},
		'{matt_pkg::ACT_TICK,   4'd0,  31'd0,     1'b1, 2'd2, 4'd2,  4'd6}
	};

	matt_cmd_if  cmd_ch ();
	matt_fire_if fire_ch ();

	multi_alarm_timer_table_top #(.ALARM_SLOTS(SLOTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.fire   (fire_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("testbench: mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Slot i fires ahead of slot j: nearer expiry first, then older arming, then lower slot.
	function automatic bit fires_first(input int i, input int j);
		logic [matt_pkg::TIME_W-1:0] ki, kj, ai, aj;
		if (slot_due_at[i] != slot_due_at[j]) begin
			ki = (slot_due_at[i] - ms_clock) ^ 32'h8000_0000;
			kj = (slot_due_at[j] - ms_clock) ^ 32'h8000_0000;
			return ki < kj;
		end
		ai = set_count - slot_set_seq[i];
		aj = set_count - slot_set_seq[j];
		if (ai != aj)
			return ai > aj;
		return i < j;
	endfunction

	function automatic bit slot_is_due(input int i);
		logic [matt_pkg::TIME_W-1:0] d;
		d = slot_due_at[i] - ms_clock;
		return d == '0 || d[matt_pkg::TIME_W-1];
	endfunction

	// Updates the predicted table and fills fired_now; returns the number fired.
	function automatic int apply_command(input logic [matt_pkg::ACTION_W-1:0] act,
			input logic [matt_pkg::ID_W-1:0] id, input logic [matt_pkg::DELAY_W-1:0] dly);
		int n, best;
		bit done;
		n = 0;
		done = 1'b0;
		case (act)
			matt_pkg::ACT_SET: begin
				set_count = set_count + 1;
				slot_live[id] = 1'b1;
				slot_due_at[id] = ms_clock + {1'b0, dly};
				slot_set_seq[id] = set_count;
			end
			matt_pkg::ACT_CANCEL: begin
				slot_live[id] = 1'b0;
			end
			matt_pkg::ACT_TICK: begin
				ms_clock = ms_clock + 1;
				while (!done && n < MAX_FIRES) begin
					best = -1;
					for (int i = 0; i < SLOTS; i++)
						if (slot_live[i] && slot_is_due(i))
							if (best < 0 || fires_first(i, best))
								best = i;
					if (best < 0) begin
						done = 1'b1;
					end else begin
						slot_live[best] = 1'b0;
						fired_now[n].alarm = 4'(best);
						fired_now[n].last = 1'b0;
						n++;
					end
				end
				if (n > 0)
					fired_now[n-1].last = 1'b1;
			end
			default: ;
		endcase
		return n;
	endfunction

	// Drives one command from a falling edge and returns at the next falling edge
	// after the transaction; valid stays high if the next command follows at once.
	task automatic send_cmd(input logic [matt_pkg::ACTION_W-1:0] act,
			input logic [matt_pkg::ID_W-1:0] id,
			input logic [matt_pkg::DELAY_W-1:0] dly, input logic typed, input int n,
			input logic [matt_pkg::ID_W-1:0] first, input logic [matt_pkg::ID_W-1:0] second);
		int cnt;
		fire_rec_t rec;
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.alarm_id <= id;
		cmd_ch.delay_ms <= dly;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		cnt = apply_command(act, id, dly);
		if (typed) begin
			for (int k = 0; k < n; k++) begin
				rec.alarm = (k == 0) ? first : second;
				rec.last = (k == n - 1);
				awaited_fires.push_back(rec);
			end
		end else begin
			for (int k = 0; k < cnt; k++)
				awaited_fires.push_back(fired_now[k]);
		end
		@(negedge clk);
	endtask

	// Mostly plain commands, with bursts that arm many slots for one tick.
	task automatic random_phase(input int count);
		int done_items, r, burst;
		logic [31:0] raw;
		logic [matt_pkg::DELAY_W-1:0] dly;
		done_items = 0;
		while (done_items < count) begin
			r = $urandom_range(99);
			raw = $urandom();
			if (r < 10) begin
				burst = $urandom_range(16, 4);
				for (int k = 0; k < burst; k++)
					send_cmd(matt_pkg::ACT_SET, 4'($urandom_range(15)),
						31'($urandom_range(2)), 1'b0, 0, 4'd0, 4'd0);
				send_cmd(matt_pkg::ACT_TICK, raw[3:0], raw[30:0], 1'b0, 0, 4'd0, 4'd0);
				done_items += burst + 1;
			end else if (r < 50) begin
				dly = ($urandom_range(3) == 0) ? raw[30:0] : 31'($urandom_range(6));
				send_cmd(matt_pkg::ACT_SET, 4'($urandom_range(15)), dly, 1'b0, 0,
					4'd0, 4'd0);
				done_items++;
			end else if (r < 62) begin
				send_cmd(matt_pkg::ACT_CANCEL, 4'($urandom_range(15)), raw[30:0], 1'b0, 0,
					4'd0, 4'd0);
				done_items++;
			end else if (r < 66) begin
				send_cmd(ACT_UNUSED, raw[3:0], raw[30:0], 1'b0, 0, 4'd0, 4'd0);
				done_items++;
			end else begin
				send_cmd(matt_pkg::ACT_TICK, raw[3:0], raw[30:0], 1'b0, 0, 4'd0, 4'd0);
				done_items++;
			end
		end
	endtask

	initial begin
		fire_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			fire_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		fire_rec_t want;
		if (arst_n && fire_ch.valid && fire_ch.ready) begin
			if (awaited_fires.size() == 0) begin
				report_mismatch($sformatf("fired alarm %0d with nothing expected",
					fire_ch.fired_alarm));
			end else begin
				want = awaited_fires.pop_front();
				if (fire_ch.fired_alarm !== want.alarm)
					report_mismatch($sformatf("fired_alarm %0d, expected %0d",
						fire_ch.fired_alarm, want.alarm));
				if (fire_ch.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
						fire_ch.last_of_run, want.last));
			end
		end
	end

	initial begin
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		ms_clock = '0;
		set_count = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_due_at[i] = '0;
			slot_set_seq[i] = '0;
		end
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = matt_pkg::ACT_SET;
		cmd_ch.alarm_id = '0;
		cmd_ch.delay_ms = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int s = 0; s < NUM_STEPS; s++)
			send_cmd(steps[s].act, steps[s].id, steps[s].dly, steps[s].typed,
				int'(steps[s].n), steps[s].first, steps[s].second);

		random_phase(RANDOM_PER_PHASE);
		idle_pct = 87;
		random_phase(RANDOM_PER_PHASE);
		idle_pct = 0;
		stall_pct = 87;
		random_phase(RANDOM_PER_PHASE);
		idle_pct = 6;
		stall_pct = 6;
		random_phase(RANDOM_PER_PHASE);
		cmd_ch.valid <= 1'b0;

		while (awaited_fires.size() != 0)
			@(posedge clk);
		// A final tick that fires nothing may still be scanning.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_fires.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
